[design/pei_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the particle Euler integrator.
// No dependencies; every module of the block imports this package.
package pei_pkg;

  // Result bits of the root and quotient units
  localparam int PEI_STEPS = 32;

  // Register reset values
  localparam logic [30:0]        TIME_STEP_RST   = 31'd655;
  localparam logic [30:0]        SIM_SCALE_RST   = 31'd65536;
  localparam logic [30:0]        FORCE_LIMIT_RST = 31'd39321600;
  localparam logic signed [31:0] GRAVITY_Z_RST   = -32'sd642253;

  // Signed Q16.16 limits
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    CFG_TIME_STEP   = 2'd0,
    CFG_SIM_SCALE   = 2'd1,
    CFG_FORCE_LIMIT = 2'd2,
    CFG_GRAVITY_Z   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last_particle;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               batch_end;
  } result_t;

endpackage

[design/pei_div.sv]
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. Depends on pei_pkg.
module pei_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic [2:0][2*pei_pkg::PEI_STEPS-1:0]    dividend,
  input  logic [pei_pkg::PEI_STEPS-1:0]           divisor,
  input  logic [SIDE_W-1:0]                       side_in,
  output logic                                    out_valid,
  output logic [2:0][pei_pkg::PEI_STEPS-1:0]      quotient,
  output logic [2:0]                              ovf,
  output logic [SIDE_W-1:0]                       side_out
);
  import pei_pkg::*;

  localparam int W = PEI_STEPS;

  // Stage 0 is the input register, stage W holds the finished quotient
  logic                vld   [W+1];
  logic [2:0][W-1:0]   rem   [W+1];
  logic [2:0][W-1:0]   quo   [W+1];
  logic [2:0][W-1:0]   low   [W+1];
  logic [W-1:0]        den   [W+1];
  logic [2:0]          ovf_s [W+1];
  logic [SIDE_W-1:0]   side  [W+1];

  logic [2:0][W:0]     trial [W];
  logic [2:0]          take  [W];

  // Shift in the next dividend bit and test against the divisor
  always_comb begin
    for (int s = 0; s < W; s++) begin
      for (int l = 0; l < 3; l++) begin
        trial[s][l] = {rem[s][l], low[s][l][W-1]};
        take[s][l]  = trial[s][l] >= {1'b0, den[s]};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= W; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int s = 0; s < W; s++) vld[s+1] <= vld[s];
    end
  end

  // Load the dividend, then subtract where the trial fits
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      rem[0][l]   <= dividend[l][2*W-1:W];
      low[0][l]   <= dividend[l][W-1:0];
      ovf_s[0][l] <= dividend[l][2*W-1:W] >= divisor;
    end
    quo[0]  <= '0;
    den[0]  <= divisor;
    side[0] <= side_in;
    for (int s = 0; s < W; s++) begin
      for (int l = 0; l < 3; l++) begin
        rem[s+1][l] <= take[s][l] ? W'(trial[s][l] - {1'b0, den[s]}) : trial[s][l][W-1:0];
        quo[s+1][l] <= {quo[s][l][W-2:0], take[s][l]};
        low[s+1][l] <= {low[s][l][W-2:0], 1'b0};
      end
      den[s+1]   <= den[s];
      ovf_s[s+1] <= ovf_s[s];
      side[s+1]  <= side[s];
    end
  end

  assign out_valid = vld[W];
  assign quotient  = quo[W];
  assign ovf       = ovf_s[W];
  assign side_out  = side[W];

endmodule

[design/pei_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on pei_pkg.
module pei_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [2*pei_pkg::PEI_STEPS-1:0]   radicand,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [pei_pkg::PEI_STEPS-1:0]     root,
  output logic [SIDE_W-1:0]                 side_out
);
  import pei_pkg::*;

  localparam int W = PEI_STEPS;

  logic              vld  [W+1];
  logic [W+1:0]      rem  [W+1];
  logic [W-1:0]      rt   [W+1];
  logic [2*W-1:0]    rad  [W+1];
  logic [SIDE_W-1:0] side [W+1];

  logic [W+3:0]      acc   [W];
  logic [W+3:0]      trial [W];
  logic              take  [W];

  // Bring down two radicand bits and test the trial root
  always_comb begin
    for (int s = 0; s < W; s++) begin
      acc[s]   = {rem[s], rad[s][2*W-1 -: 2]};
      trial[s] = {2'b00, rt[s], 2'b01};
      take[s]  = acc[s] >= trial[s];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= W; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int s = 0; s < W; s++) vld[s+1] <= vld[s];
    end
  end

  // Build the root one bit per stage
  always_ff @(posedge clk) begin
    rem[0]  <= '0;
    rt[0]   <= '0;
    rad[0]  <= radicand;
    side[0] <= side_in;
    for (int s = 0; s < W; s++) begin
      rem[s+1]  <= take[s] ? (W+2)'(acc[s] - trial[s]) : acc[s][W+1:0];
      rt[s+1]   <= {rt[s][W-2:0], take[s]};
      rad[s+1]  <= {rad[s][2*W-3:0], 2'b00};
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[W];
  assign root      = rt[W];
  assign side_out  = side[W];

endmodule

[design/particle_euler_integrator_top.sv]
`timescale 1ns / 1ps
// Top level of the particle Euler integrator: gravity, force limiting and
// velocity/position update. Depends on pei_pkg, pei_sqrt and pei_div.
//
// One particle is accepted in every clock cycle; busy never rises. Each
// particle gives one result, marked by a one-cycle done pulse, after 7 plain
// stages plus the 33-stage force square root and two 33-stage dividers, for
// limiting and for the simulation scale. Results cannot be held off, so the
// receiver must take done whenever it pulses. Registers are written through
// wr_en/wr_index/wr_data and must only change while no particle is in flight.
module particle_euler_integrator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pei_pkg::particle_t  particle,
  output logic                done,
  output pei_pkg::result_t    result,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data
);
  import pei_pkg::*;

  localparam int LATENCY = 7 + 3 * (PEI_STEPS + 1);

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] fmag;
    logic [2:0]       fneg;
    logic             limit;
    logic             last;
  } lim_ctx_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0]       fneg;
    logic             last;
  } vel_ctx_t;

  // Clamp a wide signed value to the Q16.16 range
  function automatic logic [31:0] sat_q(input logic signed [47:0] v);
    if (v > 48'(Q_MAX)) return Q_MAX;
    else if (v < 48'(Q_MIN)) return Q_MIN;
    else return v[31:0];
  endfunction

  // Configuration registers
  logic [30:0]        time_step;
  logic [30:0]        sim_scale;
  logic [30:0]        force_limit;
  logic signed [31:0] gravity_z;
  logic [61:0]        lim2;
  logic [31:0]        scale_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TIME_STEP_RST;
      sim_scale   <= SIM_SCALE_RST;
      force_limit <= FORCE_LIMIT_RST;
      gravity_z   <= GRAVITY_Z_RST;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_TIME_STEP:   time_step   <= wr_data[30:0];
        CFG_SIM_SCALE:   sim_scale   <= wr_data[30:0];
        CFG_FORCE_LIMIT: force_limit <= wr_data[30:0];
        CFG_GRAVITY_Z:   gravity_z   <= wr_data;
        default: ;
      endcase
    end
  end

  // Hold the squared limit ready for the magnitude test
  always_ff @(posedge clk) begin
    lim2 <= 62'(force_limit) * 62'(force_limit);
  end

  // Zero scale counts as one
  assign scale_div = (sim_scale == '0) ? 32'd1 : {1'b0, sim_scale};

  assign busy = 1'b0;

  // Stage 1: capture the transaction and add gravity
  logic             s1_vld;
  logic [2:0][31:0] s1_pos, s1_vel, s1_f;
  logic             s1_last;
  logic signed [47:0] gz_sum;

  assign gz_sum = 48'(particle.force_z) + 48'(gravity_z);

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_pos  <= {particle.pos_z, particle.pos_y, particle.pos_x};
    s1_vel  <= {particle.vel_z, particle.vel_y, particle.vel_x};
    s1_f    <= {sat_q(gz_sum), particle.force_y, particle.force_x};
    s1_last <= particle.last_particle;
  end

  // Stage 2: magnitudes and squares
  logic             s2_vld;
  logic [2:0][31:0] s2_pos, s2_vel, s2_fmag;
  logic [2:0]       s2_fneg;
  logic [2:0][63:0] s2_sq;
  logic             s2_last;
  logic [2:0][31:0] f_mag;

  always_comb begin
    for (int l = 0; l < 3; l++) f_mag[l] = s1_f[l][31] ? 32'd0 - s1_f[l] : s1_f[l];
  end

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      s2_fneg[l] <= s1_f[l][31];
      s2_sq[l]   <= 64'(f_mag[l]) * 64'(f_mag[l]);
    end
    s2_fmag <= f_mag;
    s2_pos  <= s1_pos;
    s2_vel  <= s1_vel;
    s2_last <= s1_last;
  end

  // Sum of squares and limit test feed the root unit
  logic [63:0] sumsq;
  lim_ctx_t    sq_in_ctx, sq_ctx;
  logic        sq_vld;
  logic [31:0] speed;

  assign sumsq = s2_sq[0] + s2_sq[1] + s2_sq[2];

  always_comb begin
    sq_in_ctx.pos   = s2_pos;
    sq_in_ctx.vel   = s2_vel;
    sq_in_ctx.fmag  = s2_fmag;
    sq_in_ctx.fneg  = s2_fneg;
    sq_in_ctx.limit = sumsq > {2'b00, lim2};
    sq_in_ctx.last  = s2_last;
  end

  pei_sqrt #(.SIDE_W($bits(lim_ctx_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .radicand  (sumsq),
    .side_in   (sq_in_ctx),
    .out_valid (sq_vld),
    .root      (speed),
    .side_out  (sq_ctx)
  );

  // Stage 4: scale each force magnitude by the limit
  logic             s4_vld;
  logic [2:0][63:0] s4_prod;
  logic [31:0]      s4_speed;
  lim_ctx_t         s4_ctx;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else     s4_vld <= sq_vld;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) s4_prod[l] <= 64'(sq_ctx.fmag[l]) * 64'(force_limit);
    s4_speed <= speed;
    s4_ctx   <= sq_ctx;
  end

  logic             d1_vld;
  logic [2:0][31:0] d1_q;
  lim_ctx_t         d1_ctx;

  pei_div #(.SIDE_W($bits(lim_ctx_t))) u_div_limit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_vld),
    .dividend  (s4_prod),
    .divisor   (s4_speed),
    .side_in   (s4_ctx),
    .out_valid (d1_vld),
    .quotient  (d1_q),
    .ovf       (),
    .side_out  (d1_ctx)
  );

  // Stage 5: pick the limited force and multiply by the time step
  logic             s5_vld;
  logic [2:0][63:0] s5_prod;
  vel_ctx_t         s5_ctx;
  logic [2:0][31:0] f_sel;

  always_comb begin
    for (int l = 0; l < 3; l++) f_sel[l] = d1_ctx.limit ? d1_q[l] : d1_ctx.fmag[l];
  end

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else     s5_vld <= d1_vld;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) s5_prod[l] <= 64'(f_sel[l]) * 64'(time_step);
    s5_ctx.pos  <= d1_ctx.pos;
    s5_ctx.vel  <= d1_ctx.vel;
    s5_ctx.fneg <= d1_ctx.fneg;
    s5_ctx.last <= d1_ctx.last;
  end

  logic             d2_vld;
  logic [2:0][31:0] d2_q;
  logic [2:0]       d2_ovf;
  vel_ctx_t         d2_ctx;

  pei_div #(.SIDE_W($bits(vel_ctx_t))) u_div_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .dividend  (s5_prod),
    .divisor   (scale_div),
    .side_in   (s5_ctx),
    .out_valid (d2_vld),
    .quotient  (d2_q),
    .ovf       (d2_ovf),
    .side_out  (d2_ctx)
  );

  // Stage 6: new velocity; an overflowed quotient always saturates
  logic               s6_vld;
  logic [2:0][31:0]   s6_vel, s6_pos;
  logic               s6_last;
  logic [2:0][32:0]   dv_mag;
  logic [2:0][47:0]   vel_sum;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_mag[l]  = d2_ovf[l] ? {1'b1, 32'd0} : {1'b0, d2_q[l]};
      vel_sum[l] = 48'($signed(d2_ctx.vel[l]))
                 + (d2_ctx.fneg[l] ? 48'd0 - 48'(dv_mag[l]) : 48'(dv_mag[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else     s6_vld <= d2_vld;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) s6_vel[l] <= sat_q($signed(vel_sum[l]));
    s6_pos  <= d2_ctx.pos;
    s6_last <= d2_ctx.last;
  end

  // Stage 7: position step magnitude
  logic             s7_vld;
  logic [2:0][61:0] s7_pm;
  logic [2:0]       s7_neg;
  logic [2:0][31:0] s7_vel, s7_pos;
  logic             s7_last;
  logic [2:0][31:0] v_mag;

  always_comb begin
    for (int l = 0; l < 3; l++) v_mag[l] = s6_vel[l][31] ? 32'd0 - s6_vel[l] : s6_vel[l];
  end

  always_ff @(posedge clk) begin
    if (rst) s7_vld <= 1'b0;
    else     s7_vld <= s6_vld;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      s7_pm[l]  <= 62'(v_mag[l]) * 62'(time_step);
      s7_neg[l] <= s6_vel[l][31];
    end
    s7_vel  <= s6_vel;
    s7_pos  <= s6_pos;
    s7_last <= s6_last;
  end

  // Stage 8: new position into the result register
  logic [2:0][47:0] dp_mag;
  logic [2:0][47:0] pos_sum;
  logic [2:0][31:0] new_pos;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dp_mag[l]  = 48'(s7_pm[l][61:16]);
      pos_sum[l] = 48'($signed(s7_pos[l])) + (s7_neg[l] ? 48'd0 - dp_mag[l] : dp_mag[l]);
      new_pos[l] = sat_q($signed(pos_sum[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s7_vld;
  end

  always_ff @(posedge clk) begin
    result.new_pos_x <= new_pos[0];
    result.new_pos_y <= new_pos[1];
    result.new_pos_z <= new_pos[2];
    result.new_vel_x <= s7_vel[0];
    result.new_vel_y <= s7_vel[1];
    result.new_vel_z <= s7_vel[2];
    result.batch_end <= s7_last;
  end

  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted transaction did not produce a result");

  // No result without a matching transaction
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  // Batch marker travels with its particle
  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    done |-> result.batch_end == $past(particle.last_particle, LATENCY))
    else $error("batch_end does not match its particle");

  // An overflowed x velocity step must clip
  a_vel_clip: assert property (@(posedge clk) disable iff (rst)
    d2_vld && d2_ovf[0] |=> s6_vel[0] == Q_MAX || s6_vel[0] == Q_MIN)
    else $error("overflowed velocity step did not saturate");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for particle_euler_integrator_top: directed and random
// particles checked against an in-bench integer predictor. Depends on pei_pkg.
module testbench;
  import pei_pkg::*;

  localparam int LATENCY = 106;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  particle_t particle;
  logic      done;
  result_t   result;
  logic      wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  // Predictor copy of the registers
  logic [30:0]        step_q;
  logic [30:0]        scale_q;
  logic [30:0]        limit_q;
  logic signed [31:0] grav_q;

  result_t expected_q[$];
  int      error_count;

  particle_euler_integrator_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .particle(particle),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Floor square root of a 64-bit unsigned value, bit by bit
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a signed value by num/den with truncation toward zero
  function automatic longint scale_trunc(longint a, logic [63:0] num, logic [63:0] den);
    logic [63:0] m;
    m = abs_of(a);
    m = (m * num) / den;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic result_t integrate(particle_t p);
    result_t r;
    longint pos[3];
    longint vel[3];
    longint frc[3];
    logic [63:0] sumsq;
    logic [63:0] speed;
    logic [63:0] mag;
    longint nv;
    longint dp;
    pos = '{p.pos_x, p.pos_y, p.pos_z};
    vel = '{p.vel_x, p.vel_y, p.vel_z};
    frc = '{p.force_x, p.force_y, p.force_z};
    frc[2] = sat_q(frc[2] + longint'(grav_q));
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag = abs_of(frc[i]);
      sumsq = sumsq + mag * mag;
    end
    if (sumsq > 64'(limit_q) * 64'(limit_q)) begin
      if (limit_q == 0) begin
        frc = '{0, 0, 0};
      end else begin
        speed = floor_root(sumsq);
        for (int i = 0; i < 3; i++) frc[i] = scale_trunc(frc[i], 64'(limit_q), speed);
      end
    end
    for (int i = 0; i < 3; i++) begin
      nv = sat_q(vel[i] + scale_trunc(frc[i], 64'(step_q),
                                      (scale_q == 0) ? 64'd1 : 64'(scale_q)));
      mag = (64'(abs_of(nv)) * 64'(step_q)) >> 16;
      dp = nv < 0 ? -longint'(mag) : longint'(mag);
      vel[i] = nv;
      pos[i] = sat_q(pos[i] + dp);
    end
    r.new_pos_x = pos[0][31:0];
    r.new_pos_y = pos[1][31:0];
    r.new_pos_z = pos[2][31:0];
    r.new_vel_x = vel[0][31:0];
    r.new_vel_y = vel[1][31:0];
    r.new_vel_z = vel[2][31:0];
    r.batch_end = p.last_particle;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result.new_pos_x, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (result.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", result.new_pos_x, want.new_pos_x);
        if (result.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", result.new_pos_y, want.new_pos_y);
        if (result.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", result.new_pos_z, want.new_pos_z);
        if (result.new_vel_x !== want.new_vel_x)
          report_mismatch("new_vel_x", result.new_vel_x, want.new_vel_x);
        if (result.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", result.new_vel_y, want.new_vel_y);
        if (result.new_vel_z !== want.new_vel_z)
          report_mismatch("new_vel_z", result.new_vel_z, want.new_vel_z);
        if (result.batch_end !== want.batch_end)
          report_mismatch("batch_end", 32'(result.batch_end), 32'(want.batch_end));
      end
    end
  end

  // Hold start for one transaction; the caller lowers it when idling
  task automatic send_particle(particle_t p);
    start    <= 1'b1;
    particle <= p;
    do @(posedge clk); while (busy);
    expected_q.push_back(integrate(p));
  endtask

  task automatic idle_sender();
    int n;
    if ($urandom_range(0, 2) != 0) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register, then idle with wr_en low before returning
  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_TIME_STEP:   step_q  = val[30:0];
      CFG_SIM_SCALE:   scale_q = val[30:0];
      CFG_FORCE_LIMIT: limit_q = val[30:0];
      default:         grav_q  = val;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65536 * 100) - 32'd3276800;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.pos_x = rand_q(); p.pos_y = rand_q(); p.pos_z = rand_q();
    p.vel_x = rand_q(); p.vel_y = rand_q(); p.vel_z = rand_q();
    p.force_x = rand_q(); p.force_y = rand_q(); p.force_z = rand_q();
    p.last_particle = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // Extremes of every field and forces at the limit boundary, at reset settings
  task automatic test_directed();
    particle_t p;
    p = '0;
    send_particle(p);
    p = {{9{32'h7fffffff}}, 1'b1};
    send_particle(p);
    p = {{9{32'h80000000}}, 1'b0};
    send_particle(p);
    p = '0;
    p.force_x = 32'h00010000; p.force_y = -32'sd65536; p.force_z = 32'h0009cccd;
    send_particle(p);
    p.force_x = 32'd39321600; p.force_y = 0; p.force_z = 32'd642253;
    send_particle(p);
    p.force_x = 32'd39321601;
    send_particle(p);
    p = '0;
    p.vel_x = 32'h7fffffff; p.vel_z = 32'h80000000; p.pos_y = 32'h7fff0000;
    p.force_x = 32'h7fffffff; p.force_z = 32'h80000000; p.last_particle = 1'b1;
    send_particle(p);
    drain();
  endtask

  // Zero limit and scale with the largest time step, then the opposite extremes
  task automatic test_edge_registers();
    write_reg(CFG_FORCE_LIMIT, 32'h0);
    write_reg(CFG_SIM_SCALE, 32'h0);
    write_reg(CFG_TIME_STEP, 32'h7fffffff);
    write_reg(CFG_GRAVITY_Z, 32'h7fffffff);
    for (int i = 0; i < 12; i++) send_particle(rand_particle());
    drain();
    write_reg(CFG_FORCE_LIMIT, 32'h7fffffff);
    write_reg(CFG_SIM_SCALE, 32'hffffffff);
    write_reg(CFG_TIME_STEP, 32'h0);
    write_reg(CFG_GRAVITY_Z, 32'h80000000);
    for (int i = 0; i < 6; i++) send_particle(rand_particle());
    drain();
  endtask

  // Random particles across several register settings
  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_TIME_STEP, (phase % 2) ? $urandom : $urandom_range(1, 131072));
      write_reg(CFG_SIM_SCALE, (phase % 3) ? $urandom_range(1, 262144) : $urandom);
      write_reg(CFG_FORCE_LIMIT, (phase == 2) ? $urandom_range(0, 65536) : $urandom);
      write_reg(CFG_GRAVITY_Z, $urandom);
      for (int i = 0; i < 190; i++) begin
        send_particle(rand_particle());
        idle_sender();
        if (i == 95) drain();
      end
      drain();
    end
  endtask

  initial begin
    error_count = 0;
    rst      <= 1'b1;
    start    <= 1'b0;
    particle <= '0;
    wr_en    <= 1'b0;
    wr_index <= CFG_TIME_STEP;
    wr_data  <= '0;
    step_q  = TIME_STEP_RST;
    scale_q = SIM_SCALE_RST;
    limit_q = FORCE_LIMIT_RST;
    grav_q  = GRAVITY_Z_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_edge_registers();
    test_random();
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
